[hdl/tetf_pkg.sv]
package tetf_pkg;

  localparam int MAX_OUT = 9;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  typedef logic [7:0]       byte_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    RUN_NONE  = 2'd0,
    RUN_DASH  = 2'd1,
    RUN_DOT1  = 2'd2,
    RUN_DOT2  = 2'd3
  } run_t;

  typedef struct packed {
    run_t pending_run;
    logic in_markup;
    logic want_open_quote;
  } state_t;

  localparam state_t STATE_RESET = '{pending_run: RUN_NONE, in_markup: 1'b0,
                                     want_open_quote: 1'b1};

  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] data;
    cnt_t                    cnt;
    logic                    want_open_quote;
  } emit_t;

  localparam byte_t CH_DASH   = 8'h2D;
  localparam byte_t CH_DOT    = 8'h2E;
  localparam byte_t CH_LT     = 8'h3C;
  localparam byte_t CH_GT     = 8'h3E;
  localparam byte_t CH_SQUOTE = 8'h27;
  localparam byte_t CH_DQUOTE = 8'h22;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_CR     = 8'h0D;

  // Entity text, first character in the top byte.
  localparam logic [63:0] ENT_MDASH  = {"&mdash;", 8'h00};
  localparam logic [63:0] ENT_HELLIP = "&hellip;";
  localparam logic [63:0] ENT_LSQUO  = {"&lsquo;", 8'h00};
  localparam logic [63:0] ENT_RSQUO  = {"&rsquo;", 8'h00};
  localparam logic [63:0] ENT_LDQUO  = {"&ldquo;", 8'h00};
  localparam logic [63:0] ENT_RDQUO  = {"&rdquo;", 8'h00};

  localparam cnt_t LEN_ONE  = cnt_t'(1);
  localparam cnt_t LEN_ENT7 = cnt_t'(7);
  localparam cnt_t LEN_ENT8 = cnt_t'(8);

  function automatic logic is_ws(byte_t b);
    return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE;
  endfunction

  // Append the first len characters of s after the bytes already in e.
  function automatic emit_t put_str(emit_t e, logic [63:0] s, cnt_t len);
    emit_t r;
    cnt_t  k;
    r = e;
    for (int j = 0; j < MAX_OUT; j++) begin
      k = cnt_t'(j) - e.cnt;
      if (cnt_t'(j) >= e.cnt && k < len) begin
        r.data[j] = s[8*(7 - int'(k[2:0])) +: 8];
      end
    end
    r.cnt = e.cnt + len;
    return r;
  endfunction

  function automatic emit_t quote_stage(emit_t e, byte_t b);
    emit_t r;
    if (b == CH_SQUOTE) begin
      r = put_str(e, e.want_open_quote ? ENT_LSQUO : ENT_RSQUO, LEN_ENT7);
    end else if (b == CH_DQUOTE) begin
      r = put_str(e, e.want_open_quote ? ENT_LDQUO : ENT_RDQUO, LEN_ENT7);
    end else begin
      r = put_str(e, {b, 56'h0}, LEN_ONE);
      r.want_open_quote = is_ws(b);
    end
    return r;
  endfunction

  // Held dashes or dots that did not complete go out literally.
  function automatic emit_t flush_run(emit_t e, run_t run);
    emit_t r;
    r = e;
    case (run)
      RUN_DASH: r = quote_stage(r, CH_DASH);
      RUN_DOT1: r = quote_stage(r, CH_DOT);
      RUN_DOT2: r = quote_stage(quote_stage(r, CH_DOT), CH_DOT);
      default:  r = e;
    endcase
    return r;
  endfunction

endpackage

[hdl/tetf_in_if.sv]
interface tetf_in_if;
  logic               valid;
  logic               ready;
  tetf_pkg::byte_t    in_byte;
  logic               end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

[hdl/tetf_out_if.sv]
interface tetf_out_if;
  logic               valid;
  logic               ready;
  tetf_pkg::byte_t    out_byte;
  logic               out_end;

  modport source (output valid, output out_byte, output out_end, input ready);
  modport sink   (input valid, input out_byte, input out_end, output ready);
endinterface

[hdl/typographic_entity_text_filter.sv]
// Typographic entity filter: takes text one byte per beat on in_ch and sends the
// text on out_ch with "--" as &mdash;, "..." as &hellip; and quotes as curly-quote
// entities; markup from '<' through '>' passes untouched. Each input beat is
// expanded into an output buffer of up to nine bytes (nine for a broken dot run
// followed by a quote entity), which drains one byte per cycle while out_ch is
// ready. The next input byte is taken only as the buffer's last byte leaves or once
// it is empty, so plain text streams at one byte per clock unless out_ch stalls.
// out_end marks the last output byte caused by a byte flagged end_of_text, after
// which all filter state is back at reset.
module typographic_entity_text_filter (
  input logic       clk,
  input logic       rst,
  tetf_in_if.sink   in_ch,
  tetf_out_if.source out_ch
);

  tetf_pkg::state_t                    state;
  tetf_pkg::state_t                    state_next;
  tetf_pkg::emit_t                     emit;
  logic [tetf_pkg::MAX_OUT-1:0][7:0]   data;
  tetf_pkg::cnt_t                      cnt;
  tetf_pkg::cnt_t                      idx;
  logic                                last;

  logic in_take;
  logic out_take;

  tetf_expand u_expand (
    .in_byte     (in_ch.in_byte),
    .end_of_text (in_ch.end_of_text),
    .state       (state),
    .emit        (emit),
    .state_next  (state_next)
  );

  assign out_ch.valid    = idx != cnt;
  assign out_ch.out_byte = data[idx];
  assign out_ch.out_end  = last && (idx + tetf_pkg::LEN_ONE == cnt);

  assign out_take = out_ch.valid && out_ch.ready;
  // Next beat may enter as the buffer's final byte leaves.
  assign in_ch.ready = !out_ch.valid || (out_take && (idx + tetf_pkg::LEN_ONE == cnt));
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tetf_pkg::STATE_RESET;
      cnt   <= '0;
      idx   <= '0;
      last  <= 1'b0;
    end else if (in_take) begin
      state <= state_next;
      cnt   <= emit.cnt;
      idx   <= '0;
      last  <= in_ch.end_of_text;
    end else if (out_take) begin
      idx <= idx + tetf_pkg::LEN_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      data <= emit.data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= tetf_pkg::cnt_t'(tetf_pkg::MAX_OUT) && idx <= cnt)
    else $error("output buffer count out of range");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    in_take && in_ch.end_of_text |=> state == tetf_pkg::STATE_RESET)
    else $error("filter state not cleared after final byte");

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    in_take && in_ch.end_of_text |=> cnt != '0 && last)
    else $error("final byte produced no output");

endmodule

[hdl/tetf_expand.sv]
module tetf_expand (
  input  tetf_pkg::byte_t  in_byte,
  input  logic             end_of_text,
  input  tetf_pkg::state_t state,
  output tetf_pkg::emit_t  emit,
  output tetf_pkg::state_t state_next
);

  tetf_pkg::emit_t e;
  tetf_pkg::run_t  run;
  logic            markup;
  logic            fresh;

  always_comb begin
    e                 = '0;
    e.want_open_quote = state.want_open_quote;
    run               = state.pending_run;
    markup            = state.in_markup;
    fresh             = 1'b0;

    if (state.in_markup) begin
      e = tetf_pkg::put_str(e, {in_byte, 56'h0}, tetf_pkg::LEN_ONE);
      if (in_byte == tetf_pkg::CH_GT) begin
        markup = 1'b0;
      end
    end else begin
      case (state.pending_run)
        tetf_pkg::RUN_DASH: begin
          if (in_byte == tetf_pkg::CH_DASH) begin
            run = tetf_pkg::RUN_NONE;
            e   = tetf_pkg::put_str(e, tetf_pkg::ENT_MDASH, tetf_pkg::LEN_ENT7);
            e.want_open_quote = 1'b0;
          end else begin
            e     = tetf_pkg::flush_run(e, run);
            run   = tetf_pkg::RUN_NONE;
            fresh = 1'b1;
          end
        end
        tetf_pkg::RUN_DOT1: begin
          if (in_byte == tetf_pkg::CH_DOT) begin
            run = tetf_pkg::RUN_DOT2;
          end else begin
            e     = tetf_pkg::flush_run(e, run);
            run   = tetf_pkg::RUN_NONE;
            fresh = 1'b1;
          end
        end
        tetf_pkg::RUN_DOT2: begin
          if (in_byte == tetf_pkg::CH_DOT) begin
            run = tetf_pkg::RUN_NONE;
            e   = tetf_pkg::put_str(e, tetf_pkg::ENT_HELLIP, tetf_pkg::LEN_ENT8);
            e.want_open_quote = 1'b0;
          end else begin
            e     = tetf_pkg::flush_run(e, run);
            run   = tetf_pkg::RUN_NONE;
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase
    end

    if (fresh) begin
      if (in_byte == tetf_pkg::CH_DASH) begin
        run = tetf_pkg::RUN_DASH;
      end else if (in_byte == tetf_pkg::CH_DOT) begin
        run = tetf_pkg::RUN_DOT1;
      end else if (in_byte == tetf_pkg::CH_LT) begin
        e      = tetf_pkg::put_str(e, {in_byte, 56'h0}, tetf_pkg::LEN_ONE);
        markup = 1'b1;
      end else begin
        e = tetf_pkg::quote_stage(e, in_byte);
      end
    end

    if (end_of_text) begin
      e          = tetf_pkg::flush_run(e, run);
      state_next = tetf_pkg::STATE_RESET;
    end else begin
      state_next.pending_run     = run;
      state_next.in_markup       = markup;
      state_next.want_open_quote = e.want_open_quote;
    end

    emit = e;
  end

endmodule

[test/tetf_text_checker.sv]
`timescale 1ns / 100ps

module tetf_text_checker (
  input  logic clk,
  input  logic rst,
  tetf_in_if   in_ch,
  tetf_out_if  out_ch,
  output int   fail_count,
  output int   backlog,
  output int   checked
);

  typedef struct packed {
    tetf_pkg::byte_t text;
    logic            last;
  } text_beat_t;

  // Filtered text still owed by the block, oldest first.
  text_beat_t expected_text[$];
  // Bytes produced by the current input beat.
  text_beat_t step_text[$];
  text_beat_t want;

  tetf_pkg::run_t held_run   = tetf_pkg::RUN_NONE;
  logic           inside_tag = 1'b0;
  logic           open_next  = 1'b1;
  int             errors     = 0;
  int             seen       = 0;

  function automatic logic is_blank(tetf_pkg::byte_t b);
    return (b >= tetf_pkg::CH_TAB && b <= tetf_pkg::CH_CR) || b == tetf_pkg::CH_SPACE;
  endfunction

  function automatic void put_byte(tetf_pkg::byte_t b);
    step_text.push_back('{text: b, last: 1'b0});
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      put_byte(tetf_pkg::byte_t'(s[i]));
    end
  endfunction

  function automatic void curl_quote(tetf_pkg::byte_t b);
    if (b == tetf_pkg::CH_SQUOTE) begin
      put_text(open_next ? "&lsquo;" : "&rsquo;");
    end else if (b == tetf_pkg::CH_DQUOTE) begin
      put_text(open_next ? "&ldquo;" : "&rdquo;");
    end else begin
      put_byte(b);
      open_next = is_blank(b);
    end
  endfunction

  function automatic void start_plain(tetf_pkg::byte_t c);
    if (c == tetf_pkg::CH_DASH) begin
      held_run = tetf_pkg::RUN_DASH;
    end else if (c == tetf_pkg::CH_DOT) begin
      held_run = tetf_pkg::RUN_DOT1;
    end else if (c == tetf_pkg::CH_LT) begin
      put_byte(c);
      inside_tag = 1'b1;
    end else begin
      curl_quote(c);
    end
  endfunction

  // broken dash/dot run goes out as literal characters
  function automatic void spill_run();
    case (held_run)
      tetf_pkg::RUN_DASH: curl_quote(tetf_pkg::CH_DASH);
      tetf_pkg::RUN_DOT1: curl_quote(tetf_pkg::CH_DOT);
      tetf_pkg::RUN_DOT2: begin
        curl_quote(tetf_pkg::CH_DOT);
        curl_quote(tetf_pkg::CH_DOT);
      end
      default: ;
    endcase
    held_run = tetf_pkg::RUN_NONE;
  endfunction

  function automatic void clear_state();
    held_run   = tetf_pkg::RUN_NONE;
    inside_tag = 1'b0;
    open_next  = 1'b1;
  endfunction

  function automatic void filter_byte(tetf_pkg::byte_t c, logic last);
    step_text.delete();
    if (inside_tag) begin
      put_byte(c);
      if (c == tetf_pkg::CH_GT) inside_tag = 1'b0;
    end else begin
      case (held_run)
        tetf_pkg::RUN_DASH: begin
          if (c == tetf_pkg::CH_DASH) begin
            held_run = tetf_pkg::RUN_NONE;
            put_text("&mdash;");
            open_next = 1'b0;
          end else begin
            spill_run();
            start_plain(c);
          end
        end
        tetf_pkg::RUN_DOT1: begin
          if (c == tetf_pkg::CH_DOT) begin
            held_run = tetf_pkg::RUN_DOT2;
          end else begin
            spill_run();
            start_plain(c);
          end
        end
        tetf_pkg::RUN_DOT2: begin
          if (c == tetf_pkg::CH_DOT) begin
            held_run = tetf_pkg::RUN_NONE;
            put_text("&hellip;");
            open_next = 1'b0;
          end else begin
            spill_run();
            start_plain(c);
          end
        end
        default: start_plain(c);
      endcase
    end
    if (last) begin
      spill_run();
      if (step_text.size() > 0) step_text[step_text.size() - 1].last = 1'b1;
      clear_state();
    end
    foreach (step_text[i]) expected_text.push_back(step_text[i]);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_text.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) filter_byte(in_ch.in_byte, in_ch.end_of_text);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_text.size() == 0) begin
          errors++;
          $error("out_byte %h (out_end %b) arrived with nothing expected",
                 out_ch.out_byte, out_ch.out_end);
        end else begin
          want = expected_text.pop_front();
          seen++;
          if (out_ch.out_byte !== want.text) begin
            errors++;
            $error("out_byte mismatch: expected %h, got %h", want.text, out_ch.out_byte);
          end
          if (out_ch.out_end !== want.last) begin
            errors++;
            $error("out_end mismatch: expected %b, got %b", want.last, out_ch.out_end);
          end
        end
      end
    end
    fail_count <= errors;
    backlog    <= expected_text.size();
    checked    <= seen;
  end

endmodule

[test/typographic_entity_text_filter_tb.sv]
`timescale 1ns / 100ps

module typographic_entity_text_filter_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 230;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tetf_in_if  in_ch ();
  tetf_out_if out_ch ();

  int   fail_count;
  int   backlog;
  int   checked;
  int   cycles     = 0;
  int   items_sent = 0;
  int   texts_sent = 0;
  logic tx_steady  = 1'b0;
  logic rx_steady  = 1'b0;

  typographic_entity_text_filter i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tetf_text_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .backlog    (backlog),
    .checked    (checked)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("typographic_entity_text_filter_tb failed");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_beat(tetf_pkg::byte_t b, logic last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.end_of_text <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_text(input tetf_pkg::byte_t txt[$]);
    foreach (txt[i]) send_beat(txt[i], i == txt.size() - 1);
    texts_sent++;
    if ($urandom_range(0, 3) == 0) tx_steady = !tx_steady;
  endtask

  // Stop sending and let every owed byte drain.
  task automatic drain_all();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  // result sink with random stalls
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
    end
  end

  initial begin
    tetf_pkg::byte_t txt[$];
    int              goal;
    int              len;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= 8'h00;
    in_ch.end_of_text <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // dash pair, quote sides around an entity
    send_text('{tetf_pkg::CH_DQUOTE, "A", tetf_pkg::CH_DASH, tetf_pkg::CH_DASH,
                tetf_pkg::CH_DQUOTE});
    // dot run broken by a quote, then a dot broken by a dash held to the end
    send_text('{tetf_pkg::CH_DOT, tetf_pkg::CH_DOT, tetf_pkg::CH_SQUOTE, tetf_pkg::CH_DOT,
                tetf_pkg::CH_DASH});
    // quote inside markup, side unchanged after it
    send_text('{tetf_pkg::CH_LT, tetf_pkg::CH_SQUOTE, tetf_pkg::CH_GT,
                tetf_pkg::CH_SQUOTE});
    send_text('{tetf_pkg::CH_DOT, tetf_pkg::CH_DOT, tetf_pkg::CH_DOT, tetf_pkg::CH_DOT});
    // byte extremes, whitespace before a quote, unclosed markup
    send_text('{8'h00, tetf_pkg::CH_TAB, tetf_pkg::CH_SQUOTE, 8'hFF, tetf_pkg::CH_LT});
    send_text('{tetf_pkg::CH_DASH});
    send_text('{tetf_pkg::CH_DASH, tetf_pkg::CH_DASH, tetf_pkg::CH_DASH});
    drain_all();

    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      txt.delete();
      len = $urandom_range(1, 12);
      while (txt.size() < len) begin
        case ($urandom_range(0, 15))
          0, 1, 2, 3: txt.push_back(tetf_pkg::byte_t'("a" + $urandom_range(0, 25)));
          4: txt.push_back(($urandom_range(0, 5) == 5) ? tetf_pkg::CH_SPACE :
                           tetf_pkg::byte_t'($urandom_range(tetf_pkg::CH_TAB,
                                                            tetf_pkg::CH_CR)));
          5: txt.push_back(tetf_pkg::CH_SPACE);
          6: txt.push_back(tetf_pkg::CH_DASH);
          7: begin
            txt.push_back(tetf_pkg::CH_DASH);
            txt.push_back(tetf_pkg::CH_DASH);
          end
          8: txt.push_back(tetf_pkg::CH_DOT);
          9: repeat (3) txt.push_back(tetf_pkg::CH_DOT);
          10: txt.push_back(tetf_pkg::CH_SQUOTE);
          11: txt.push_back(tetf_pkg::CH_DQUOTE);
          12: begin
            txt.push_back(tetf_pkg::CH_LT);
            repeat ($urandom_range(0, 3)) begin
              case ($urandom_range(0, 3))
                0: txt.push_back(tetf_pkg::CH_DQUOTE);
                1: txt.push_back(tetf_pkg::CH_DASH);
                2: txt.push_back(tetf_pkg::CH_DOT);
                default: txt.push_back(tetf_pkg::byte_t'("a" + $urandom_range(0, 25)));
              endcase
            end
            if ($urandom_range(0, 7) != 0) txt.push_back(tetf_pkg::CH_GT);
          end
          13: txt.push_back(tetf_pkg::byte_t'($urandom_range(0, 255)));
          14: txt.push_back(tetf_pkg::CH_GT);
          default: txt.push_back(($urandom_range(0, 3) == 0) ? tetf_pkg::CH_LT :
                                                               tetf_pkg::CH_SPACE);
        endcase
      end
      send_text(txt);
      if (texts_sent % 9 == 0) drain_all();
    end

    drain_all();
    repeat (20) @(posedge clk);
    $display("Filtered %0d bytes in %0d texts, %0d output beats compared.",
             items_sent, texts_sent, checked);
    $display("Covered dash/dot runs, broken runs, quote sides, markup, byte extremes.");
    if (fail_count == 0 && backlog == 0) begin
      $display("typographic_entity_text_filter_tb passed");
    end else begin
      $display("typographic_entity_text_filter_tb failed");
    end
    $finish;
  end

endmodule

[typographic_entity_text_filter.f]
hdl/tetf_pkg.sv
hdl/tetf_in_if.sv
hdl/tetf_out_if.sv
hdl/tetf_expand.sv
hdl/typographic_entity_text_filter.sv
test/tetf_text_checker.sv
test/typographic_entity_text_filter_tb.sv
